>>> design/huf_pkg.sv
package huf_pkg;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_PATH  = 2'd1;
  localparam logic [1:0] ST_OVERSIZE  = 2'd2;
  localparam logic [1:0] ST_NO_CHILD  = 2'd3;

  // tree path bytes
  localparam logic [7:0] PATH_UP    = 8'h55;
  localparam logic [7:0] PATH_LEFT  = 8'h4C;
  localparam logic [7:0] PATH_RIGHT = 8'h52;

  // one result request
  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       end_of_stream;
    logic [1:0] status;
    logic       last;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

>>> design/huf_fifo.sv
module huf_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

>>> design/huf_engine.sv
module huf_engine #(
  parameter int NODE_COUNT       = 1024,
  parameter int LEAF_COUNT       = 512,
  parameter int STACK_DEPTH      = 256,
  parameter int SIZE_FIELD_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_empty,
  input  logic [7:0]        byte_data,
  output logic              byte_pop,
  input  logic              res_full,
  output logic              res_push,
  output huf_pkg::res_t     res_data
);

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int NFW = $clog2(NODE_COUNT + 1);
  localparam int LIW = $clog2(LEAF_COUNT);
  localparam int LCW = $clog2(LEAF_COUNT + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SHW = 8 * SIZE_FIELD_BYTES;

  // stream phases
  localparam logic [2:0] PH_OUTER   = 3'd0;
  localparam logic [2:0] PH_PATHLEN = 3'd1;
  localparam logic [2:0] PH_LEAFCNT = 3'd2;
  localparam logic [2:0] PH_ENDIDX  = 3'd3;
  localparam logic [2:0] PH_PATH    = 3'd4;
  localparam logic [2:0] PH_LEAVES  = 3'd5;
  localparam logic [2:0] PH_SLACK   = 3'd6;
  localparam logic [2:0] PH_DATA    = 3'd7;

  // previous path step
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_U    = 2'd1;
  localparam logic [1:0] STEP_L    = 2'd2;
  localparam logic [1:0] STEP_R    = 2'd3;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_CLR  = 3'd2;
  localparam logic [2:0] S_WRD  = 3'd3;
  localparam logic [2:0] S_WCH  = 3'd4;
  localparam logic [2:0] S_WLF  = 3'd5;
  localparam logic [2:0] S_WSY  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  // memories
  logic [NW-1:0]  left_mem  [NODE_COUNT];
  logic [NW-1:0]  right_mem [NODE_COUNT];
  logic [LIW:0]   leaf_mem  [NODE_COUNT];
  logic [7:0]     sym_mem   [LEAF_COUNT];
  logic [NW-1:0]  stack_mem [STACK_DEPTH];

  logic [NW-1:0]  left_q, right_q;
  logic [LIW:0]   leaf_q;
  logic [7:0]     sym_q;
  logic [NW-1:0]  stack_q;

  // control and state registers
  logic [2:0]     state_r, state_nxt;
  logic [2:0]     phase_r, phase_nxt;
  logic [SHW-1:0] shift_r, shift_nxt;
  logic [15:0]    cnt_r, cnt_nxt;
  logic [15:0]    ttot_r, ttot_nxt;
  logic [15:0]    plen_r, plen_nxt;
  logic [LCW-1:0] ltot_r, ltot_nxt;
  logic [9:0]     eidx_r, eidx_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [NW-1:0]  build_r, build_nxt;
  logic           bvalid_r, bvalid_nxt;
  logic [NFW-1:0] nfree_r, nfree_nxt;
  logic [LCW-1:0] lctr_r, lctr_nxt;
  logic [1:0]     prev_r, prev_nxt;
  logic [NW-1:0]  walk_r, walk_nxt;
  logic           err_r, err_nxt;
  logic [2:0]     bit_r, bit_nxt;
  logic [7:0]     byte_r, byte_nxt;
  huf_pkg::res_t  pend_r, pend_nxt;
  logic           pendv_r, pendv_nxt;

  // memory port controls
  logic           lr_re;
  logic [NW-1:0]  lr_raddr;
  logic           left_we, right_we;
  logic [NW-1:0]  left_waddr, right_waddr, left_wdata, right_wdata;
  logic           leaf_re, leaf_we;
  logic [NW-1:0]  leaf_raddr, leaf_waddr;
  logic [LIW:0]   leaf_wdata;
  logic           sym_re, sym_we;
  logic [LIW-1:0] sym_raddr, sym_waddr;
  logic           stk_re, stk_we;
  logic [SAW-1:0] stk_raddr, stk_waddr;
  logic [NW-1:0]  stk_wdata;

  logic           stall;
  logic [SHW-1:0] field;
  logic [63:0]    fval;
  logic [15:0]    cnt1;
  logic [17:0]    need;
  logic [NW-1:0]  child;
  logic [LIW-1:0] idx;

  // next phase after a section ends, skipping empty sections
  function automatic logic [2:0] skip_phase(input logic [2:0] p, input logic [15:0] plen,
                                            input logic [LCW-1:0] ltot, input logic [15:0] ttot);
    logic [2:0] q;
    q = p;
    if (q == PH_PATH && plen == '0) q = PH_LEAVES;
    if (q == PH_LEAVES && ltot == '0) q = PH_SLACK;
    if (q == PH_SLACK && ttot == '0) q = PH_DATA;
    return q;
  endfunction

  assign field = {shift_r[SHW-9:0], byte_data};
  assign fval  = 64'(field);
  assign cnt1  = cnt_r + 16'd1;
  assign need  = 18'(3 * SIZE_FIELD_BYTES) + 18'(plen_r) + 18'(ltot_r);
  assign child = byte_r[bit_r] ? right_q : left_q;
  assign idx   = leaf_q[LIW-1:0];
  assign stall = res_push && res_full;
  assign byte_pop = (state_r == S_IDLE) && !byte_empty;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    cnt_nxt    = cnt_r;
    ttot_nxt   = ttot_r;
    plen_nxt   = plen_r;
    ltot_nxt   = ltot_r;
    eidx_nxt   = eidx_r;
    sp_nxt     = sp_r;
    build_nxt  = build_r;
    bvalid_nxt = bvalid_r;
    nfree_nxt  = nfree_r;
    lctr_nxt   = lctr_r;
    prev_nxt   = prev_r;
    walk_nxt   = walk_r;
    err_nxt    = err_r;
    bit_nxt    = bit_r;
    byte_nxt   = byte_r;
    pend_nxt   = pend_r;
    pendv_nxt  = pendv_r;
    res_push   = 1'b0;
    res_data   = pend_r;
    res_data.last = 1'b0;
    lr_re      = 1'b0;
    lr_raddr   = walk_r;
    left_we    = 1'b0;
    right_we   = 1'b0;
    left_waddr = build_r;
    right_waddr = build_r;
    left_wdata = '0;
    right_wdata = '0;
    leaf_re    = 1'b0;
    leaf_raddr = child;
    leaf_we    = 1'b0;
    leaf_waddr = build_r;
    leaf_wdata = '0;
    sym_re     = 1'b0;
    sym_raddr  = idx;
    sym_we     = 1'b0;
    sym_waddr  = cnt_r[LIW-1:0];
    stk_re     = 1'b0;
    stk_raddr  = SAW'(sp_r - 1'b1);
    stk_we     = 1'b0;
    stk_waddr  = sp_r[SAW-1:0];
    stk_wdata  = build_r;

    case (state_r)
      S_IDLE: begin
        if (!byte_empty) begin
          byte_nxt = byte_data;
          if (err_r) begin
            // latched error: drop the byte
          end else if (phase_r <= PH_ENDIDX) begin
            shift_nxt = field;
            cnt_nxt   = cnt1;
            if (32'(cnt1) >= SIZE_FIELD_BYTES) begin
              shift_nxt = '0;
              cnt_nxt   = '0;
              walk_nxt  = '0;
              case (phase_r)
                PH_OUTER: begin
                  if (fval > 64'd65535 || fval < 64'(3 * SIZE_FIELD_BYTES)) begin
                    pend_nxt = '{8'd0, 1'b0, 1'b0, huf_pkg::ST_OVERSIZE, 1'b0};
                    pendv_nxt = 1'b1;
                    err_nxt = 1'b1;
                    state_nxt = S_FIN;
                  end else begin
                    ttot_nxt  = fval[15:0];
                    phase_nxt = PH_PATHLEN;
                  end
                end
                PH_PATHLEN: begin
                  if (fval > 64'd65535) begin
                    pend_nxt = '{8'd0, 1'b0, 1'b0, huf_pkg::ST_OVERSIZE, 1'b0};
                    pendv_nxt = 1'b1;
                    err_nxt = 1'b1;
                    state_nxt = S_FIN;
                  end else begin
                    plen_nxt  = fval[15:0];
                    phase_nxt = PH_LEAFCNT;
                  end
                end
                PH_LEAFCNT: begin
                  if (fval > 64'(LEAF_COUNT)) begin
                    pend_nxt = '{8'd0, 1'b0, 1'b0, huf_pkg::ST_OVERSIZE, 1'b0};
                    pendv_nxt = 1'b1;
                    err_nxt = 1'b1;
                    state_nxt = S_FIN;
                  end else begin
                    ltot_nxt  = fval[LCW-1:0];
                    phase_nxt = PH_ENDIDX;
                  end
                end
                default: begin
                  if (fval > 64'd1023 || need > 18'(ttot_r)) begin
                    pend_nxt = '{8'd0, 1'b0, 1'b0, huf_pkg::ST_OVERSIZE, 1'b0};
                    pendv_nxt = 1'b1;
                    err_nxt = 1'b1;
                    state_nxt = S_FIN;
                  end else begin
                    eidx_nxt   = fval[9:0];
                    ttot_nxt   = ttot_r - need[15:0];
                    // fresh builder: root cleared, root on the stack
                    left_we    = 1'b1;
                    left_waddr = '0;
                    right_we   = 1'b1;
                    right_waddr = '0;
                    leaf_we    = 1'b1;
                    leaf_waddr = '0;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = '0;
                    nfree_nxt  = NFW'(1);
                    sp_nxt     = SPW'(1);
                    build_nxt  = '0;
                    bvalid_nxt = 1'b0;
                    lctr_nxt   = '0;
                    prev_nxt   = STEP_NONE;
                    phase_nxt  = skip_phase(PH_PATH, plen_r, ltot_r, ttot_r - need[15:0]);
                  end
                end
              endcase
            end
          end else if (phase_r == PH_PATH) begin
            // path byte: build the node table
            logic [1:0] code;
            code = huf_pkg::ST_OK;
            if (byte_data == huf_pkg::PATH_UP) begin
              if ((prev_r == STEP_L || prev_r == STEP_R) && bvalid_r) begin
                if (lctr_r >= ltot_r) begin
                  code = huf_pkg::ST_OVERSIZE;
                end else begin
                  leaf_we    = 1'b1;
                  leaf_wdata = {1'b1, lctr_r[LIW-1:0]};
                  lctr_nxt   = lctr_r + 1'b1;
                end
              end
              if (code == huf_pkg::ST_OK && sp_r == '0) begin
                code = huf_pkg::ST_BAD_PATH;
              end
              if (code == huf_pkg::ST_OK) begin
                sp_nxt     = sp_r - 1'b1;
                stk_re     = 1'b1;
                bvalid_nxt = 1'b1;
                prev_nxt   = STEP_U;
                state_nxt  = S_POP;
              end
            end else if (byte_data == huf_pkg::PATH_LEFT || byte_data == huf_pkg::PATH_RIGHT) begin
              if (!bvalid_r) begin
                code = huf_pkg::ST_BAD_PATH;
              end else if (32'(nfree_r) >= NODE_COUNT || 32'(sp_r) >= STACK_DEPTH) begin
                code = huf_pkg::ST_OVERSIZE;
              end else begin
                nfree_nxt  = nfree_r + 1'b1;
                if (byte_data == huf_pkg::PATH_LEFT) begin
                  left_we    = 1'b1;
                  left_wdata = nfree_r[NW-1:0];
                  prev_nxt   = STEP_L;
                end else begin
                  right_we    = 1'b1;
                  right_wdata = nfree_r[NW-1:0];
                  prev_nxt    = STEP_R;
                end
                leaf_we    = 1'b1;
                leaf_waddr = nfree_r[NW-1:0];
                stk_we     = 1'b1;
                sp_nxt     = sp_r + 1'b1;
                build_nxt  = nfree_r[NW-1:0];
                state_nxt  = S_CLR;
              end
            end else begin
              code = huf_pkg::ST_BAD_PATH;
            end
            if (code != huf_pkg::ST_OK) begin
              pend_nxt  = '{8'd0, 1'b0, 1'b0, code, 1'b0};
              pendv_nxt = 1'b1;
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else if (cnt1 >= plen_r) begin
              cnt_nxt   = '0;
              shift_nxt = '0;
              walk_nxt  = '0;
              phase_nxt = skip_phase(PH_LEAVES, plen_r, ltot_r, ttot_r);
            end else begin
              cnt_nxt = cnt1;
            end
          end else if (phase_r == PH_LEAVES) begin
            // leaf symbol bytes
            sym_we = (32'(cnt_r) < LEAF_COUNT);
            if (cnt1 >= 16'(ltot_r)) begin
              cnt_nxt   = '0;
              shift_nxt = '0;
              walk_nxt  = '0;
              phase_nxt = skip_phase(PH_SLACK, plen_r, ltot_r, ttot_r);
            end else begin
              cnt_nxt = cnt1;
            end
          end else if (phase_r == PH_SLACK) begin
            if (cnt1 >= ttot_r) begin
              cnt_nxt   = '0;
              shift_nxt = '0;
              walk_nxt  = '0;
              phase_nxt = PH_DATA;
            end else begin
              cnt_nxt = cnt1;
            end
          end else begin
            bit_nxt   = 3'd7;
            state_nxt = S_WRD;
          end
        end
      end
      S_POP: begin
        build_nxt = stack_q;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        // clear both children of the new node
        left_we   = 1'b1;
        right_we  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WRD: begin
        lr_re     = 1'b1;
        state_nxt = S_WCH;
      end
      S_WCH: begin
        if (child == '0) begin
          if (pendv_r) res_push = 1'b1;
          pend_nxt  = '{8'd0, 1'b0, 1'b0, huf_pkg::ST_NO_CHILD, 1'b0};
          pendv_nxt = 1'b1;
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          walk_nxt  = child;
          leaf_re   = 1'b1;
          state_nxt = S_WLF;
        end
      end
      S_WLF: begin
        if (leaf_q[LIW]) begin
          if (16'(idx) == 16'(eidx_r)) begin
            // end leaf: back to the outer header
            if (pendv_r) res_push = 1'b1;
            pend_nxt  = '{8'd0, 1'b0, 1'b1, huf_pkg::ST_OK, 1'b0};
            pendv_nxt = 1'b1;
            phase_nxt = PH_OUTER;
            shift_nxt = '0;
            cnt_nxt   = '0;
            walk_nxt  = '0;
            state_nxt = S_FIN;
          end else begin
            sym_re    = 1'b1;
            state_nxt = S_WSY;
          end
        end else if (bit_r == 3'd0) begin
          state_nxt = S_FIN;
        end else begin
          bit_nxt   = bit_r - 3'd1;
          lr_re     = 1'b1;
          state_nxt = S_WCH;
        end
      end
      S_WSY: begin
        if (pendv_r) res_push = 1'b1;
        pend_nxt  = '{sym_q, 1'b1, 1'b0, huf_pkg::ST_OK, 1'b0};
        pendv_nxt = 1'b1;
        walk_nxt  = '0;
        if (bit_r == 3'd0) begin
          state_nxt = S_FIN;
        end else begin
          bit_nxt   = bit_r - 3'd1;
          state_nxt = S_WRD;
        end
      end
      default: begin
        // S_FIN: final result of the byte carries last
        if (pendv_r) begin
          res_push      = 1'b1;
          res_data.last = 1'b1;
        end
        pendv_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers hold while a result push is blocked by a full result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_OUTER;
      shift_r  <= '0;
      cnt_r    <= '0;
      ttot_r   <= '0;
      plen_r   <= '0;
      ltot_r   <= '0;
      eidx_r   <= '0;
      sp_r     <= '0;
      build_r  <= '0;
      bvalid_r <= 1'b0;
      nfree_r  <= NFW'(1);
      lctr_r   <= '0;
      prev_r   <= STEP_NONE;
      walk_r   <= '0;
      err_r    <= 1'b0;
      bit_r    <= '0;
      pendv_r  <= 1'b0;
    end else if (!stall) begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      shift_r  <= shift_nxt;
      cnt_r    <= cnt_nxt;
      ttot_r   <= ttot_nxt;
      plen_r   <= plen_nxt;
      ltot_r   <= ltot_nxt;
      eidx_r   <= eidx_nxt;
      sp_r     <= sp_nxt;
      build_r  <= build_nxt;
      bvalid_r <= bvalid_nxt;
      nfree_r  <= nfree_nxt;
      lctr_r   <= lctr_nxt;
      prev_r   <= prev_nxt;
      walk_r   <= walk_nxt;
      err_r    <= err_nxt;
      bit_r    <= bit_nxt;
      pendv_r  <= pendv_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!stall) begin
      byte_r <= byte_nxt;
      pend_r <= pend_nxt;
    end
  end

  // node child tables
  always_ff @(posedge clk) begin
    if (!stall && left_we) left_mem[left_waddr] <= left_wdata;
    if (!stall && right_we) right_mem[right_waddr] <= right_wdata;
    if (!stall && lr_re) begin
      left_q  <= left_mem[lr_raddr];
      right_q <= right_mem[lr_raddr];
    end
  end

  // leaf flag and index table
  always_ff @(posedge clk) begin
    if (!stall && leaf_we) leaf_mem[leaf_waddr] <= leaf_wdata;
    if (!stall && leaf_re) leaf_q <= leaf_mem[leaf_raddr];
  end

  // leaf symbols
  always_ff @(posedge clk) begin
    if (!stall && sym_we) sym_mem[sym_waddr] <= byte_data;
    if (!stall && sym_re) sym_q <= sym_mem[sym_raddr];
  end

  // ancestor stack
  always_ff @(posedge clk) begin
    if (!stall && stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (!stall && stk_re) stack_q <= stack_mem[stk_raddr];
  end

endmodule

>>> design/huffman_stream_decoder.sv
// Byte-stream Huffman decoder with an in-band serialized tree. Push one stream
// byte per request on in_*; decoded symbols, end-of-stream marks and error
// status come out as requests on out_*, with out_last set on the final result
// caused by each byte (a byte may cause none). Bytes land in a two-entry input
// queue and results in a four-entry output queue, so either side may stall.
// Header, leaf-symbol and slack bytes are handled in the idle state; a valid
// path byte also passes through a stack-pop or child-clear state. A code byte
// walks the tree one code bit at a time through the registered node-table and
// leaf-table reads, with a symbol-table read and a fresh root lookup for each
// decoded symbol. After an error the block drops every byte until reset.
module huffman_stream_decoder #(
  parameter int NODE_COUNT       = 1024,
  parameter int LEAF_COUNT       = 512,
  parameter int STACK_DEPTH      = 256,
  parameter int SIZE_FIELD_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_data_byte,
  output logic       in_full,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_symbol,
  output logic       out_symbol_valid,
  output logic       out_end_of_stream,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic          byte_empty, byte_pop;
  logic [7:0]    byte_data;
  logic          res_full, res_push;
  huf_pkg::res_t res_in, res_out;

  // input queue
  huf_fifo #(.W(8), .DEPTH(2)) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (in_data_byte),
    .full  (in_full),
    .pop   (byte_pop),
    .dout  (byte_data),
    .empty (byte_empty)
  );

  // parser and tree walker
  huf_engine #(
    .NODE_COUNT       (NODE_COUNT),
    .LEAF_COUNT       (LEAF_COUNT),
    .STACK_DEPTH      (STACK_DEPTH),
    .SIZE_FIELD_BYTES (SIZE_FIELD_BYTES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_empty (byte_empty),
    .byte_data  (byte_data),
    .byte_pop   (byte_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_in)
  );

  // result queue
  huf_fifo #(.W(huf_pkg::RES_W), .DEPTH(4)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign out_symbol        = res_out.symbol;
  assign out_symbol_valid  = res_out.symbol_valid;
  assign out_end_of_stream = res_out.end_of_stream;
  assign out_status        = res_out.status;
  assign out_last          = res_out.last;

`ifndef SYNTH
  // engine never pulls from an empty input queue
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(byte_pop && byte_empty)) else $error("byte pulled from empty queue");

  // a result blocked by a full queue is held unchanged
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_full) |=> (res_push && $stable(res_in)))
    else $error("blocked result changed");

  // an error result always closes its byte
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_in.status != huf_pkg::ST_OK) |-> res_in.last)
    else $error("error result without last");

  // error results carry no symbol
  a_err_nosym: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_in.status != huf_pkg::ST_OK) |->
    (!res_in.symbol_valid && !res_in.end_of_stream))
    else $error("error result with symbol");
`endif

endmodule
